### hw/rtl/pfsr_pkg.sv
package pfsr_pkg;

  // Field and datapath widths
  localparam int RAW_W      = 19;
  localparam int DIVIDEND_W = RAW_W - 1;
  localparam int DIVISOR_W  = 10;
  localparam int TARGET_W   = 8;
  localparam int GAIN_W     = 16;
  localparam int CEIL_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int ERR_W      = 9;
  localparam int DIFF_W     = 11;
  localparam int INTEG_W    = 7;
  localparam int TERM_W     = 13;
  localparam int ACC_W      = 30;

  // Control constants
  localparam int TEMP_LOW       = 1;
  localparam int TEMP_HIGH      = 149;
  localparam int INTEGRAL_LIMIT = 120;
  localparam int WINDUP_MARGIN  = 4;
  localparam int GAIN_FRAC_BITS = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_DIVISOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_CEILING  = 3'd5;

  // Register reset values
  localparam logic [DIVISOR_W-1:0] RST_TEMP_DIVISOR = 10'd10;
  localparam logic [TARGET_W-1:0]  RST_TARGET_TEMP  = 8'd75;
  localparam logic [GAIN_W-1:0]    RST_GAIN_P       = 16'd2560;
  localparam logic [GAIN_W-1:0]    RST_GAIN_I       = 16'd512;
  localparam logic [GAIN_W-1:0]    RST_GAIN_D       = 16'd2560;
  localparam logic [CEIL_W-1:0]    RST_PWM_CEILING  = 8'd120;

  typedef struct packed {
    logic signed [RAW_W-1:0] sensor_raw;
    logic                    sensor_present;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              hold_first;
  } duty_t;

endpackage

### hw/rtl/pfsr_div.sv
module pfsr_div #(
  parameter int DIVIDEND_W = pfsr_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = pfsr_pkg::DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Bring down one dividend bit and try the subtraction
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Control: count one quotient bit a cycle, flag the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the quotient in as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

### hw/rtl/pid_fan_speed_regulator.sv
// PID fan speed regulator.
// sample channel (sample_valid/sample_ready, payload sample) takes one control
// tick: a raw reading and a sensor-present flag. duty channel
// (duty_valid/duty_ready, payload duty) gives at most one drive update per tick.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per write; the user is to write it only while the block is idle, which the
// block itself does not enforce. Unknown indexes are ignored. A tick with the
// sensor absent or a negative reading is dropped in the transfer cycle itself.
// Otherwise an 18-step restoring divider scales the reading, then a bit-serial
// multiply-accumulate walks the 16 gain bits, one per cycle, for all three
// terms together, and a finish step clamps and loads the output register.
// A tick whose temperature lies out of range returns to idle after the divide.
// One tick is worked on at a time; sample_ready is high only between ticks and
// never in reset.
// A finished result sits in the output register; while the receiver stalls
// the next tick may still be taken, and its own result waits in the finish
// step until the register frees. State is committed only on that step.
// Reset (rst, synchronous) restores register defaults, clears the error
// history and integral, marks the fan stopped and empties the output.
module pid_fan_speed_regulator #(
  parameter int INTEGRAL_LIMIT = pfsr_pkg::INTEGRAL_LIMIT,
  parameter int WINDUP_MARGIN  = pfsr_pkg::WINDUP_MARGIN,
  parameter int GAIN_FRAC_BITS = pfsr_pkg::GAIN_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  pfsr_pkg::sample_t                    sample,
  output logic                                 duty_valid,
  input  logic                                 duty_ready,
  output pfsr_pkg::duty_t                      duty,
  input  logic                                 cfg_we,
  input  logic [pfsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ERR_W   = pfsr_pkg::ERR_W;
  localparam int DIFF_W  = pfsr_pkg::DIFF_W;
  localparam int INTEG_W = pfsr_pkg::INTEG_W;
  localparam int TERM_W  = pfsr_pkg::TERM_W;
  localparam int ACC_W   = pfsr_pkg::ACC_W;
  localparam int GAIN_W  = pfsr_pkg::GAIN_W;
  localparam int QW      = pfsr_pkg::DIVIDEND_W;
  localparam int BIT_W   = $clog2(GAIN_W);
  localparam int FRAC    = GAIN_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MAC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [pfsr_pkg::DIVISOR_W-1:0] temp_divisor;
  logic [pfsr_pkg::TARGET_W-1:0]  target_temp;
  logic [GAIN_W-1:0]              gain_p;
  logic [GAIN_W-1:0]              gain_i;
  logic [GAIN_W-1:0]              gain_d;
  logic [pfsr_pkg::CEIL_W-1:0]    pwm_ceiling;

  // Controller state
  logic signed [ERR_W-1:0] last_error;
  logic signed [ERR_W-1:0] prior_error;
  logic [INTEG_W-1:0]      integral_sum;
  logic                    fan_running;

  // Working registers for the current tick
  logic signed [ERR_W-1:0]  e_r;
  logic signed [DIFF_W-1:0] d_r;
  logic [INTEG_W-1:0]       integ_r;
  logic signed [ACC_W-1:0]  acc;
  logic [BIT_W-1:0]         bit_idx;

  logic                                 accept;
  logic                                 div_start;
  logic                                 div_done;
  logic [QW-1:0]                        quotient;
  logic [pfsr_pkg::DIVISOR_W-1:0]       div_eff;
  logic                                 in_range;
  logic signed [ERR_W-1:0]              e_now;
  logic signed [9:0]                    e10;
  logic signed [9:0]                    cand;
  logic signed [9:0]                    wsum;
  logic [INTEG_W-1:0]                   integ_now;
  logic signed [DIFF_W-1:0]             d_now;
  logic signed [TERM_W-1:0]             term;
  logic signed [ACC_W-1:0]              top;
  logic signed [ACC_W-1:0]              drive_c;
  logic                                 out_free;
  logic                                 leave_fin;

  assign sample_ready = (state == S_IDLE) && !rst;
  assign accept       = sample_valid && sample_ready;
  assign div_start    = accept && sample.sensor_present && !sample.sensor_raw[pfsr_pkg::RAW_W-1];
  assign div_eff      = (temp_divisor == '0) ? pfsr_pkg::DIVISOR_W'(1) : temp_divisor;

  pfsr_div #(
    .DIVIDEND_W (QW),
    .DIVISOR_W  (pfsr_pkg::DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample.sensor_raw[QW-1:0]),
    .divisor  (div_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Range check, error and integral update on the quotient
  assign in_range = (quotient >= QW'(pfsr_pkg::TEMP_LOW)) &&
                    (quotient <= QW'(pfsr_pkg::TEMP_HIGH));
  assign e_now    = $signed({1'b0, quotient[7:0]}) - $signed({1'b0, target_temp});
  assign e10      = 10'(e_now);
  assign cand     = $signed({3'b000, integral_sum}) + e10;
  assign wsum     = e10 + $signed(10'(WINDUP_MARGIN));
  assign d_now    = DIFF_W'(e_now) - DIFF_W'(last_error) - DIFF_W'(last_error)
                  + DIFF_W'(prior_error);

  always_comb begin
    if (cand > $signed(10'(INTEGRAL_LIMIT))) begin
      integ_now = INTEG_W'(INTEGRAL_LIMIT);
    end else if (cand[9] || wsum[9]) begin
      integ_now = '0;
    end else begin
      integ_now = cand[INTEG_W-1:0];
    end
  end

  // One gain bit of all three products
  always_comb begin
    term = '0;
    if (gain_p[bit_idx]) begin
      term = term + TERM_W'(e_r);
    end
    if (gain_d[bit_idx]) begin
      term = term - TERM_W'(d_r);
    end
    if (gain_i[bit_idx]) begin
      term = term + $signed(TERM_W'(integ_r));
    end
  end

  // Clamp the drive to 0..ceiling
  assign top = $signed(ACC_W'(pwm_ceiling) << FRAC);
  always_comb begin
    if (acc > top) begin
      drive_c = top;
    end else if (acc[ACC_W-1]) begin
      drive_c = '0;
    end else begin
      drive_c = acc;
    end
  end

  assign out_free  = !duty_valid || duty_ready;
  assign leave_fin = (state == S_FIN) && out_free;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= in_range ? S_MAC : S_IDLE;
          end
        end
        S_MAC: begin
          if (bit_idx == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture tick values, then accumulate MSB first
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      e_r     <= e_now;
      d_r     <= d_now;
      integ_r <= integ_now;
      acc     <= '0;
      bit_idx <= BIT_W'(GAIN_W - 1);
    end else if (state == S_MAC) begin
      acc     <= {acc[ACC_W-2:0], 1'b0} + ACC_W'(term);
      bit_idx <= bit_idx - BIT_W'(1);
    end
  end

  // Commit controller state and load the result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      prior_error  <= '0;
      integral_sum <= '0;
      fan_running  <= 1'b0;
      duty_valid   <= 1'b0;
    end else begin
      if (leave_fin) begin
        prior_error  <= last_error;
        last_error   <= e_r;
        integral_sum <= integ_r;
      end
      if (leave_fin && (drive_c != '0)) begin
        fan_running     <= 1'b1;
        duty_valid      <= 1'b1;
        duty.pwm_duty   <= drive_c[FRAC +: pfsr_pkg::DUTY_W];
        duty.hold_first <= 1'b0;
      end else if (leave_fin && fan_running) begin
        fan_running     <= 1'b0;
        duty_valid      <= 1'b1;
        duty.pwm_duty   <= '0;
        duty.hold_first <= 1'b1;
      end else if (duty_valid && duty_ready) begin
        duty_valid <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_divisor <= pfsr_pkg::RST_TEMP_DIVISOR;
      target_temp  <= pfsr_pkg::RST_TARGET_TEMP;
      gain_p       <= pfsr_pkg::RST_GAIN_P;
      gain_i       <= pfsr_pkg::RST_GAIN_I;
      gain_d       <= pfsr_pkg::RST_GAIN_D;
      pwm_ceiling  <= pfsr_pkg::RST_PWM_CEILING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfsr_pkg::REG_TEMP_DIVISOR: temp_divisor <= cfg_data[pfsr_pkg::DIVISOR_W-1:0];
        pfsr_pkg::REG_TARGET_TEMP:  target_temp  <= cfg_data[pfsr_pkg::TARGET_W-1:0];
        pfsr_pkg::REG_GAIN_P:       gain_p       <= cfg_data[GAIN_W-1:0];
        pfsr_pkg::REG_GAIN_I:       gain_i       <= cfg_data[GAIN_W-1:0];
        pfsr_pkg::REG_GAIN_D:       gain_d       <= cfg_data[GAIN_W-1:0];
        pfsr_pkg::REG_PWM_CEILING:  pwm_ceiling  <= cfg_data[pfsr_pkg::CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Checks
  a_integ_limit: assert property (@(posedge clk) disable iff (rst)
    integral_sum <= INTEG_W'(INTEGRAL_LIMIT))
    else $error("integral above its limit");

  a_stop_gives_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(fan_running)) |-> (duty_valid && duty.hold_first))
    else $error("fan stopped without a hold result");

  a_duty_running: assert property (@(posedge clk) disable iff (rst)
    (duty_valid && duty.pwm_duty != '0) |-> fan_running)
    else $error("nonzero drive while fan marked stopped");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pfsr_pkg::*;

  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 113;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  // Indexes past the register list; writes to these must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample = '0;
  logic                  duty_valid;
  logic                  duty_ready = 1'b0;
  duty_t                 duty;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers, reset values
  logic [DIVISOR_W-1:0] cfg_div    = RST_TEMP_DIVISOR;
  logic [TARGET_W-1:0]  cfg_target = RST_TARGET_TEMP;
  logic [GAIN_W-1:0]    cfg_kp     = RST_GAIN_P;
  logic [GAIN_W-1:0]    cfg_ki     = RST_GAIN_I;
  logic [GAIN_W-1:0]    cfg_kd     = RST_GAIN_D;
  logic [CEIL_W-1:0]    cfg_ceil   = RST_PWM_CEILING;

  // Predictor copy of the control state
  logic signed [ERR_W-1:0] err_last  = '0;
  logic signed [ERR_W-1:0] err_prior = '0;
  logic [INTEG_W-1:0]      integ_acc = '0;
  logic                    fan_on    = 1'b0;

  duty_t       duty_due[$];
  int          mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_span;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  pid_fan_speed_regulator uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .duty_valid   (duty_valid),
    .duty_ready   (duty_ready),
    .duty         (duty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 120);
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 70) return GAIN_W'($urandom_range(0, 4095));
    return GAIN_W'($urandom_range(0, 65535));
  endfunction

  function automatic sample_t tick(input int raw, input bit present);
    sample_t s;
    s.sensor_raw     = RAW_W'(raw);
    s.sensor_present = present;
    return s;
  endfunction

  // Work out the duty update, if any, that one control tick causes
  function automatic void predict_duty(input sample_t s);
    longint raw, dv, deg, err, cand, integ, slope, drive, top;
    duty_t  upd;
    if (!s.sensor_present) return;
    raw = longint'($signed(s.sensor_raw));
    dv  = (cfg_div == '0) ? 1 : longint'(cfg_div);
    deg = raw / dv;
    if (deg < TEMP_LOW || deg > TEMP_HIGH) return;
    err  = deg - longint'(cfg_target);
    cand = longint'(integ_acc) + err;
    if (cand > INTEGRAL_LIMIT) integ = INTEGRAL_LIMIT;
    else if (cand < 0) integ = 0;
    else if (err < -WINDUP_MARGIN) integ = 0;
    else integ = cand;
    slope = err - 2 * longint'(err_last) + longint'(err_prior);
    drive = longint'(cfg_kp) * err - longint'(cfg_kd) * slope + longint'(cfg_ki) * integ;
    top   = longint'(cfg_ceil) << GAIN_FRAC_BITS;
    if (drive > top) drive = top;
    else if (drive < 0) drive = 0;
    integ_acc = integ[INTEG_W-1:0];
    err_prior = err_last;
    err_last  = err[ERR_W-1:0];
    if (drive != 0) begin
      upd.pwm_duty   = drive[GAIN_FRAC_BITS +: DUTY_W];
      upd.hold_first = 1'b0;
      fan_on         = 1'b1;
      duty_due.push_back(upd);
    end else if (fan_on) begin
      upd.pwm_duty   = '0;
      upd.hold_first = 1'b1;
      fan_on         = 1'b0;
      duty_due.push_back(upd);
    end
  endfunction

  // Random tick: mostly in-range readings, many of them near the target
  function automatic sample_t make_sample();
    sample_t     s;
    int unsigned dv, pick;
    int          t;
    dv   = (cfg_div == '0) ? 1 : int'(cfg_div);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s.sensor_raw     = RAW_W'($urandom);
      s.sensor_present = 1'($urandom_range(0, 1));
      return s;
    end
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0: t = TEMP_LOW - 1;
        1: t = TEMP_LOW;
        2: t = TEMP_HIGH;
        default: t = TEMP_HIGH + 1;
      endcase
    end else if (pick < 65) begin
      t = int'(cfg_target) + int'($urandom_range(0, 40)) - 20;
      if (t < TEMP_LOW) t = TEMP_LOW;
      if (t > TEMP_HIGH) t = TEMP_HIGH;
    end else begin
      t = int'($urandom_range(TEMP_LOW, TEMP_HIGH));
    end
    s.sensor_raw     = RAW_W'(t * int'(dv) + int'($urandom_range(0, dv - 1)));
    s.sensor_present = ($urandom_range(0, 19) != 0);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one tick and hold it until the transfer
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = tx_steady ? 0 : gap_len();
    @(negedge clk);
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    predict_duty(s);
  endtask

  // Drop valid, wait for every outstanding update, then let the block go quiet
  task automatic settle(input int unsigned extra);
    @(negedge clk);
    sample_valid <= 1'b0;
    while (duty_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEMP_DIVISOR: cfg_div    = data[DIVISOR_W-1:0];
      REG_TARGET_TEMP:  cfg_target = data[TARGET_W-1:0];
      REG_GAIN_P:       cfg_kp     = data;
      REG_GAIN_I:       cfg_ki     = data;
      REG_GAIN_D:       cfg_kd     = data;
      REG_PWM_CEILING:  cfg_ceil   = data[CEIL_W-1:0];
      default: ;
    endcase
  endtask

  // Write all registers, with junk above the narrower fields, plus the spare indexes
  task automatic apply_settings(input logic [DIVISOR_W-1:0] dv,
                                input logic [TARGET_W-1:0] tgt,
                                input logic [GAIN_W-1:0] kp,
                                input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd,
                                input logic [CEIL_W-1:0] ceil);
    logic [31:0] junk;
    junk = $urandom;
    settle(SETTLE_CYCLES);
    write_reg(REG_SPARE_LO, junk[31:16]);
    write_reg(REG_TEMP_DIVISOR, {junk[CFG_DATA_W-DIVISOR_W-1:0], dv});
    write_reg(REG_TARGET_TEMP, {junk[7:0], tgt});
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_PWM_CEILING, {junk[15:8], ceil});
    write_reg(REG_SPARE_HI, ~junk[31:16]);
  endtask

  // Reset settings: absent sensor, range edges, zero drive while stopped
  task automatic test_ranges();
    send_sample(tick(800, 1'b0));
    send_sample(tick(750, 1'b1));
    send_sample(tick(900, 1'b1));
    send_sample(tick(9, 1'b1));
    send_sample(tick(10, 1'b1));
    send_sample(tick(1499, 1'b1));
    send_sample(tick(1500, 1'b1));
    send_sample(tick(-9, 1'b1));
    send_sample(tick(-131072, 1'b1));
    send_sample(tick(262143, 1'b1));
    send_sample(tick(750, 1'b1));
  endtask

  // Zero divisor, sub-unit drive, hold on stopping, saturation, zero ceiling
  task automatic test_special_cases();
    apply_settings(10'd0, 8'd80, 16'd1, 16'd0, 16'd0, 8'd255);
    send_sample(tick(85, 1'b1));
    send_sample(tick(80, 1'b1));
    send_sample(tick(80, 1'b1));
    send_sample(tick(40, 1'b1));
    send_sample(tick(0, 1'b1));
    apply_settings(10'd1, 8'd0, 16'hffff, 16'd0, 16'd0, 8'd255);
    send_sample(tick(149, 1'b1));
    apply_settings(10'd1, 8'd0, 16'hffff, 16'd0, 16'd0, 8'd0);
    send_sample(tick(149, 1'b1));
    send_sample(tick(149, 1'b1));
  endtask

  // Random ticks under a run of settings, reset values and extremes first
  task automatic test_random_settings();
    logic [DIVISOR_W-1:0] dv;
    logic [TARGET_W-1:0]  tgt;
    logic [CEIL_W-1:0]    ceil;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(RST_TEMP_DIVISOR, RST_TARGET_TEMP, RST_GAIN_P, RST_GAIN_I,
                          RST_GAIN_D, RST_PWM_CEILING);
        1: apply_settings(10'd1023, 8'd0, 16'hffff, 16'hffff, 16'hffff, 8'd255);
        2: apply_settings(10'd1, 8'd150, 16'd0, 16'hffff, 16'hffff, 8'd1);
        default: begin
          case ($urandom_range(0, 9))
            0: dv = '0;
            1, 2, 3, 4, 5: dv = DIVISOR_W'($urandom_range(1, 16));
            6, 7: dv = DIVISOR_W'($urandom_range(17, 200));
            default: dv = DIVISOR_W'($urandom_range(201, 1023));
          endcase
          tgt  = ($urandom_range(0, 9) == 0) ? TARGET_W'($urandom_range(0, 150))
                                             : TARGET_W'($urandom_range(30, 120));
          ceil = ($urandom_range(0, 4) == 0) ? CEIL_W'($urandom_range(0, 255))
                                             : CEIL_W'($urandom_range(20, 255));
          apply_settings(dv, tgt, rand_gain(), rand_gain(), rand_gain(), ceil);
        end
      endcase
      // one phase runs flat out on both sides
      tx_steady = (ph == 4);
      rx_steady = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(make_sample());
        // hold off the sender until the block has drained
        if (ph == 5 && n % 25 == 24) settle(0);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: stall at random, unless running steady
  always @(negedge clk) begin
    if (rx_stall_left != 0) begin
      duty_ready    <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_steady) begin
      duty_ready <= 1'b1;
    end else begin
      rx_span = gap_len();
      duty_ready    <= (rx_span == 0);
      rx_stall_left <= (rx_span == 0) ? 0 : rx_span - 1;
    end
  end

  // Check each duty transfer against the oldest outstanding update
  always @(posedge clk) begin
    if (!rst && duty_valid && duty_ready) begin
      if (duty_due.size() == 0) begin
        report_mismatch("duty transfer with none outstanding", int'(duty), 0);
      end else begin
        if (duty.pwm_duty !== duty_due[0].pwm_duty)
          report_mismatch("pwm_duty", int'(duty.pwm_duty), int'(duty_due[0].pwm_duty));
        if (duty.hold_first !== duty_due[0].hold_first)
          report_mismatch("hold_first", int'(duty.hold_first),
                          int'(duty_due[0].hold_first));
        void'(duty_due.pop_front());
      end
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (duty_valid && duty_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** pid_fan_speed_regulator: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ranges();
    test_special_cases();
    test_random_settings();
    settle(SETTLE_CYCLES);
    if (duty_due.size() != 0)
      report_mismatch("updates never transferred", 0, duty_due.size());
    if (mismatches == 0)
      $display("** pid_fan_speed_regulator: PASSED **");
    else
      $display("** pid_fan_speed_regulator: FAILED **");
    $finish;
  end

endmodule

### pid_fan_speed_regulator.f
hw/rtl/pfsr_pkg.sv
hw/rtl/pfsr_div.sv
hw/rtl/pid_fan_speed_regulator.sv
verif/testbench.sv
